@@ hw/rtl/npcs_pkg.sv @@
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types and constants of the nearest palette color search block
// ----------------------------------------------------------------------------
package npcs_pkg;

  // palette storage
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned RGB_W         = 24;

  // field widths
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW   = 4;

  // squared distance: 3 * 255^2 fits, start value 3 * 256^2 + 1 too
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned DIST_W  = SQ_W + 2;
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256 + 1);

  // search count arithmetic, wide enough for 1 << 15
  localparam int unsigned CNT_W = 17;

  // opcodes carried in tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_EN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_BITS = 1'd1;

  // register reset values
  localparam logic              OVERLAY_EN_RST   = 1'b1;
  localparam logic [CFG_DW-1:0] OVERLAY_BITS_RST = 4'd8;

  typedef enum logic [1:0] {
    NPCS_IDLE,
    NPCS_SEARCH,
    NPCS_DRAIN,
    NPCS_DONE
  } npcs_state_e;

endpackage

@@ hw/rtl/npcs_ram.sv @@
// ----------------------------------------------------------------------------
// npcs_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module npcs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/nearest_palette_color_search.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// palette of rgb entries with a nearest color query by squared distance
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: entry_index, red, green, blue
//                                             tuser: opcode (0 load, 1 query)
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: nearest_index
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// a load or a disabled query goes to the done state, then into the output register once it is free
// a query searches min(2^overlay_bits, PALETTE_DEPTH) entries: the one distance
//   unit looks at one palette entry per cycle from the single ram read port
// one item at a time: s_axis_tready is high only while the sequencer is idle,
//   and a finished result waits in the output register while the next beat enters
// reset clears a valid flag per palette entry; an entry never loaded reads as
//   black, so there is no clearing pass
//
module nearest_palette_color_search
  import npcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // entry_index, red, green, blue
  input  logic                 s_axis_tuser,   // opcode
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // nearest_index
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic              overlay_en_q;
  logic [CFG_DW-1:0] overlay_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlay_en_q   <= OVERLAY_EN_RST;
      overlay_bits_q <= OVERLAY_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OVERLAY_EN:   overlay_en_q   <= cfg_wdata_i[0];
        CFG_OVERLAY_BITS: overlay_bits_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // last entry searched: 2^bits saturated to the palette depth, minus one
  logic [CNT_W-1:0]  search_cnt;
  logic [PAL_AW-1:0] last_addr;

  always_comb begin
    search_cnt = CNT_W'(1) << overlay_bits_q;
    if (search_cnt > CNT_W'(PALETTE_DEPTH)) begin
      search_cnt = CNT_W'(PALETTE_DEPTH);
    end
    last_addr = PAL_AW'(search_cnt - CNT_W'(1));
  end

  // --------------------------------------------------------------------------
  // input beat fields
  // --------------------------------------------------------------------------
  logic              in_op;
  logic [IDX_W-1:0]  in_idx;
  logic [RGB_W-1:0]  in_rgb;
  logic              in_beat;
  logic              load_ok;

  assign in_op   = s_axis_tuser;
  assign in_idx  = s_axis_tdata[7:0];
  assign in_rgb  = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // loads outside the palette are dropped
  assign load_ok = in_beat && (in_op == OP_LOAD) &&
                   ({1'b0, in_idx} < (IDX_W + 1)'(PALETTE_DEPTH));

  // --------------------------------------------------------------------------
  // palette ram and per entry valid flags
  // --------------------------------------------------------------------------
  logic [PAL_AW-1:0]        rd_addr_q, rd_addr_d;
  logic [RGB_W-1:0]         ram_rdata;
  logic [PALETTE_DEPTH-1:0] valid_q;

  npcs_ram #(
    .Width (RGB_W),
    .Depth (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (in_idx[PAL_AW-1:0]),
    .wdata_i (in_rgb),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (load_ok) begin
      valid_q[in_idx[PAL_AW-1:0]] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  npcs_state_e state_q, state_d;
  logic        rd_issue;
  logic        v1_q, v2_q;
  logic        out_free;
  logic        out_load;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NPCS_IDLE: begin
        if (in_beat) begin
          state_d = ((in_op == OP_QUERY) && overlay_en_q) ? NPCS_SEARCH : NPCS_DONE;
        end
      end
      NPCS_SEARCH: begin
        if (rd_addr_q == last_addr) begin
          state_d = NPCS_DRAIN;
        end
      end
      NPCS_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = NPCS_DONE;
        end
      end
      NPCS_DONE: begin
        if (out_free) begin
          state_d = NPCS_IDLE;
        end
      end
      default: state_d = NPCS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_issue      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      NPCS_IDLE:   s_axis_tready = 1'b1;
      NPCS_SEARCH: rd_issue      = 1'b1;
      NPCS_DRAIN:  ;
      NPCS_DONE:   out_load      = out_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NPCS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // read address walks the palette from entry 0
  always_comb begin
    rd_addr_d = rd_addr_q;
    if (in_beat) begin
      rd_addr_d = '0;
    end else if (rd_issue) begin
      rd_addr_d = rd_addr_q + PAL_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
    end else begin
      rd_addr_q <= rd_addr_d;
    end
  end

  // query color held for the whole search
  logic [CHAN_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      red_q   <= in_rgb[23:16];
      green_q <= in_rgb[15:8];
      blue_q  <= in_rgb[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // distance unit: ram read, squares, sum and compare
  // --------------------------------------------------------------------------
  logic              ent_valid_q;
  logic [PAL_AW-1:0] idx1_q, idx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= rd_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_valid_q <= valid_q[rd_addr_q];
    idx1_q      <= rd_addr_q;
  end

  // entries never loaded read as black
  logic [RGB_W-1:0]  entry;
  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    entry = ent_valid_q ? ram_rdata : '0;
    dr    = abs_diff(red_q,   entry[23:16]);
    dg    = abs_diff(green_q, entry[15:8]);
    db    = abs_diff(blue_q,  entry[7:0]);
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_q <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_q <= SQ_W'(db) * SQ_W'(db);
    idx2_q <= idx1_q;
  end

  // strict less keeps the lowest index on a tie
  logic [DIST_W-1:0] cand_dist;
  logic [DIST_W-1:0] min_q, min_d;
  logic [PAL_AW-1:0] best_q, best_d;

  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_comb begin
    min_d  = min_q;
    best_d = best_q;
    if (in_beat) begin
      min_d  = DIST_START;
      best_d = '0;
    end else if (v2_q && (cand_dist < min_q)) begin
      min_d  = cand_dist;
      best_d = idx2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    best_q <= best_d;
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic       m_valid_q;
  logic [7:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= IDX_W'(best_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ sim/npcs_checker.sv @@
// ----------------------------------------------------------------------------
// npcs_checker
// watches the streams and configuration writes of the nearest palette color
// search block, keeps a shadow palette and compares every result beat
// ----------------------------------------------------------------------------
module npcs_checker
  import npcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // entry_index, red, green, blue
  input  logic                 s_axis_tuser,   // opcode
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [7:0]           m_axis_tdata,   // nearest_index
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic                 final_check_i,
  output int unsigned          result_cnt_o,
  output int unsigned          fail_cnt_o
);

  localparam int unsigned MAX_PRINTED = 50;

  logic [RGB_W-1:0]  palette_shadow [PALETTE_DEPTH];
  logic              overlay_en_q;
  logic [CFG_DW-1:0] overlay_bits_q;
  logic [IDX_W-1:0]  expected_index_q [$];
  logic [IDX_W-1:0]  want_index;
  logic [IDX_W-1:0]  beat_entry;
  logic [CHAN_W-1:0] beat_red, beat_green, beat_blue;
  logic              final_done;
  int unsigned       result_cnt;
  int unsigned       fail_cnt;

  assign result_cnt_o = result_cnt;
  assign fail_cnt_o   = fail_cnt;

  initial begin
    result_cnt = 0;
    fail_cnt   = 0;
    final_done = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_cnt < MAX_PRINTED) begin
      $display("%0t npcs mismatch: %s", $time, what);
    end
    fail_cnt++;
  endtask

  function automatic logic [SQ_W-1:0] chan_dist_sq(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // walk the searched entries, strictly-less compare keeps the lowest index
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
    int unsigned       span;
    int unsigned       i;
    logic [DIST_W-1:0] best_dist;
    logic [DIST_W-1:0] cand_dist;
    logic [IDX_W-1:0]  best_idx;
    logic [RGB_W-1:0]  rgb;
    best_dist = DIST_START;
    best_idx  = '0;
    if (!overlay_en_q) return '0;
    span = (overlay_bits_q > 4'd8) ? PALETTE_DEPTH : (1 << overlay_bits_q);
    if (span > PALETTE_DEPTH) span = PALETTE_DEPTH;
    for (i = 0; i < span; i++) begin
      rgb       = palette_shadow[i];
      cand_dist = DIST_W'(chan_dist_sq(r, rgb[23:16])) + DIST_W'(chan_dist_sq(g, rgb[15:8]))
                + DIST_W'(chan_dist_sq(b, rgb[7:0]));
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best_idx  = IDX_W'(i);
      end
    end
    return best_idx;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (palette_shadow[i]) palette_shadow[i] = '0;
      overlay_en_q   = OVERLAY_EN_RST;
      overlay_bits_q = OVERLAY_BITS_RST;
      expected_index_q.delete();
    end else begin
      // result first: a beat entering at this edge cannot be answered yet
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt <= result_cnt + 1;
        if (expected_index_q.size() == 0) begin
          report_mismatch($sformatf("nearest_index %0d with nothing expected", m_axis_tdata));
        end else begin
          want_index = expected_index_q.pop_front();
          if (m_axis_tdata !== want_index) begin
            report_mismatch($sformatf("nearest_index got %0d want %0d",
                                      m_axis_tdata, want_index));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat_entry = s_axis_tdata[7:0];
        beat_red   = s_axis_tdata[15:8];
        beat_green = s_axis_tdata[23:16];
        beat_blue  = s_axis_tdata[31:24];
        if (s_axis_tuser == OP_LOAD) begin
          if (int'(beat_entry) < PALETTE_DEPTH) begin
            palette_shadow[beat_entry] = {beat_red, beat_green, beat_blue};
          end
          expected_index_q.push_back('0);
        end else begin
          expected_index_q.push_back(nearest_entry(beat_red, beat_green, beat_blue));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OVERLAY_EN: begin
            overlay_en_q = cfg_wdata_i[0];
          end
          CFG_OVERLAY_BITS: begin
            overlay_bits_q = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (final_check_i && !final_done) begin
        final_done = 1'b1;
        if (expected_index_q.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", expected_index_q.size()));
        end
      end
    end
  end

endmodule

@@ sim/tb_nearest_palette_color_search.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search
// drives loads and nearest color queries through the input stream under
// several register settings and handshake profiles; the checker beside the
// block predicts every result beat and counts mismatches
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search;
  import npcs_pkg::*;

  localparam int unsigned HALF_PERIOD     = 5;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  // longest query walks all 256 entries and then drains the pipeline
  localparam int unsigned DRAIN_CYCLES    = 300;
  // receiver hold-off in the pressure phase
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned TIMEOUT         = 15_000_000;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;   // entry_index, red, green, blue
  logic                 s_axis_tuser;   // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // nearest_index
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DW-1:0]    cfg_wdata_i;
  logic                 final_check;
  int unsigned          result_cnt;
  int unsigned          fail_cnt;

  // handshake profile, percent of cycles
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        pressure_req   = 1'b0;

  int unsigned beats_sent = 0;
  // recently loaded colors, used to aim queries near or onto palette entries
  logic [23:0] loaded_rgb [$];

  always #HALF_PERIOD clk_i = ~clk_i;

  nearest_palette_color_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  npcs_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .final_check_i (final_check),
    .result_cnt_o  (result_cnt),
    .fail_cnt_o    (fail_cnt)
  );

  // small random step around a palette channel, clamped to the 8-bit range
  function automatic logic [7:0] jitter(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // one input beat; valid stays high after acceptance so beats can go back to back
  task automatic send_beat(input logic op, input logic [7:0] entry,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r, entry};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  // drop valid and wait until every accepted beat has its result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (result_cnt != beats_sent) @(posedge clk_i);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // random traffic under one register setting and one handshake profile
  task automatic run_phase(input logic en, input logic [CFG_DW-1:0] bits,
                           input int unsigned src_pct, input int unsigned sink_pct,
                           input bit press);
    int unsigned span;
    int unsigned k;
    int unsigned mode;
    logic        op;
    logic [7:0]  entry, r, g, b;
    logic [23:0] base;
    // spare bits of the enable write are random, only bit 0 counts
    write_reg(CFG_OVERLAY_EN, {3'($urandom_range(0, 7)), en});
    write_reg(CFG_OVERLAY_BITS, bits);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (press) pressure_req <= 1'b1;
    // loads mostly land inside the searched window so queries see them
    span = (bits > 4'd8) ? 255 : (1 << bits) - 1;
    for (k = 0; k < ITEMS_PER_PHASE; k++) begin
      op    = ($urandom_range(0, 1) == 1) ? OP_QUERY : OP_LOAD;
      entry = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, span)) : 8'($urandom());
      mode  = $urandom_range(0, 9);
      if (mode == 0) begin
        // channel extremes
        r = {8{1'($urandom_range(0, 1))}};
        g = {8{1'($urandom_range(0, 1))}};
        b = {8{1'($urandom_range(0, 1))}};
      end else if (mode <= 4 && loaded_rgb.size() > 0) begin
        // on or near a loaded color: duplicates and ties come from here
        base = loaded_rgb[$urandom_range(0, loaded_rgb.size() - 1)];
        r = jitter(base[23:16]);
        g = jitter(base[15:8]);
        b = jitter(base[7:0]);
      end else begin
        r = 8'($urandom());
        g = 8'($urandom());
        b = 8'($urandom());
      end
      if (op == OP_LOAD) begin
        loaded_rgb.push_back({r, g, b});
        if (loaded_rgb.size() > 32) void'(loaded_rgb.pop_front());
      end
      send_beat(op, entry, r, g, b);
    end
    pressure_req <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin : sink
    int unsigned held;
    bit          hold_done;
    held          = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("[nearest_palette_color_search] ERROR");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_OVERLAY_EN;
    cfg_wdata_i   = '0;
    final_check   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset palette is all black, so everything ties onto entry 0
    send_beat(OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0);
    send_beat(OP_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
    // primaries, white at the top entry, and a duplicate red for a tie
    send_beat(OP_LOAD,  8'd1,   8'd255, 8'd0,   8'd0);
    send_beat(OP_LOAD,  8'd2,   8'd0,   8'd255, 8'd0);
    send_beat(OP_LOAD,  8'd3,   8'd0,   8'd0,   8'd255);
    send_beat(OP_LOAD,  8'd255, 8'd255, 8'd255, 8'd255);
    send_beat(OP_LOAD,  8'd4,   8'd255, 8'd0,   8'd0);
    // tie between entries 1 and 4, lowest index wins
    send_beat(OP_QUERY, 8'd0,   8'd250, 8'd10,  8'd5);
    send_beat(OP_QUERY, 8'd0,   8'd255, 8'd255, 8'd255);
    send_beat(OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd0);
    send_beat(OP_QUERY, 8'd77,  8'd10,  8'd10,  8'd240);
    // zero index bits: only entry 0 searched
    write_reg(CFG_OVERLAY_BITS, 4'd0);
    send_beat(OP_QUERY, 8'd0,   8'd255, 8'd0,   8'd0);
    write_reg(CFG_OVERLAY_BITS, 4'd1);
    send_beat(OP_QUERY, 8'd0,   8'd255, 8'd0,   8'd0);
    write_reg(CFG_OVERLAY_BITS, 4'd2);
    send_beat(OP_QUERY, 8'd0,   8'd0,   8'd0,   8'd255);
    // too many index bits saturate to the whole palette
    write_reg(CFG_OVERLAY_BITS, 4'd15);
    send_beat(OP_QUERY, 8'd0,   8'd255, 8'd255, 8'd250);
    write_reg(CFG_OVERLAY_BITS, 4'd9);
    send_beat(OP_QUERY, 8'd0,   8'd250, 8'd250, 8'd250);
    // overlay disabled: queries answer 0, loads still land
    write_reg(CFG_OVERLAY_EN, 4'b1110);
    send_beat(OP_QUERY, 8'd0,   8'd255, 8'd0,   8'd0);
    send_beat(OP_LOAD,  8'd0,   8'd128, 8'd128, 8'd128);
    write_reg(CFG_OVERLAY_EN, 4'b0001);
    write_reg(CFG_OVERLAY_BITS, 4'd8);
    send_beat(OP_QUERY, 8'd0,   8'd120, 8'd130, 8'd128);
    send_beat(OP_QUERY, 8'd0,   8'd255, 8'd255, 8'd255);

    // random phases: setting, sender idle, receiver stall, pressure
    run_phase(1'b1, 4'd8,  0,  0,  1'b0);
    run_phase(1'b1, 4'd3,  64, 0,  1'b0);
    run_phase(1'b1, 4'd4,  0,  64, 1'b1);
    run_phase(1'b1, 4'd15, 23, 23, 1'b0);
    run_phase(1'b0, 4'd6,  0,  0,  1'b0);
    run_phase(1'b1, 4'd0,  64, 0,  1'b0);
    run_phase(1'b1, 4'd2,  0,  64, 1'b0);
    run_phase(1'b1, 4'd8,  23, 23, 1'b0);

    // drain, let any stray beat show up, then look for leftovers
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    final_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[nearest_palette_color_search] OK");
    end else begin
      $display("[nearest_palette_color_search] ERROR");
    end
    $finish;
  end

endmodule
